// File: rtl/core/ptp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg
// shared types and constants of the projected point-in-triangle pipeline
// ----------------------------------------------------------------------------
package ptp_pkg;

   localparam int COORD_W    = 32;              // signed fixed-point coordinate
   localparam int NUM_COORDS = 12;              // three vertices and query, xyz each
   localparam int TOL_W      = 16;              // tolerance register width
   localparam int DIV_STEPS  = 32;              // quotient bits, one per stage
   localparam int LATENCY    = DIV_STEPS + 14;  // accepting edge to result edge

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef logic signed [COORD_W-1:0] coord_set_type [NUM_COORDS];

endpackage

// File: rtl/core/point_in_triangle_projected.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_triangle_projected
// tests a query point against a triangle by projecting along a normal axis
// ----------------------------------------------------------------------------
// pipeline: 13 arithmetic stages, 32 restoring divider stages, one output register
// throughput: one transfer per cycle, busy stays low; the receiver cannot stall
// reset: synchronous, clears all stage valid bits and sets tolerance to 1
// csr writes are taken in any cycle, ready stays high
module point_in_triangle_projected #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic signed [31:0] req_vert_a_x,
   input  logic signed [31:0] req_vert_a_y,
   input  logic signed [31:0] req_vert_a_z,
   input  logic signed [31:0] req_vert_b_x,
   input  logic signed [31:0] req_vert_b_y,
   input  logic signed [31:0] req_vert_b_z,
   input  logic signed [31:0] req_vert_c_x,
   input  logic signed [31:0] req_vert_c_y,
   input  logic signed [31:0] req_vert_c_z,
   input  logic signed [31:0] req_query_x,
   input  logic signed [31:0] req_query_y,
   input  logic signed [31:0] req_query_z,
   // result strobe
   output logic        rsp_valid,
   output logic        rsp_contains,
   output logic [1:0]  rsp_drop_axis,
   // tolerance register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_tolerance
);

   // squared compare needs room for n^2 shifted by twice the fraction bits
   localparam int CmpW = 2 * COORD_FRAC_BITS + 96;
   localparam int DS   = ptp_pkg::DIV_STEPS;

   // ------------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------------
   logic accept;
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   logic [ptp_pkg::TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= ptp_pkg::TOL_W'(1);
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_tolerance;
      end
   end

   ptp_pkg::coord_set_type req_p;
   assign req_p[0]  = req_vert_a_x;
   assign req_p[1]  = req_vert_a_y;
   assign req_p[2]  = req_vert_a_z;
   assign req_p[3]  = req_vert_b_x;
   assign req_p[4]  = req_vert_b_y;
   assign req_p[5]  = req_vert_b_z;
   assign req_p[6]  = req_vert_c_x;
   assign req_p[7]  = req_vert_c_y;
   assign req_p[8]  = req_vert_c_z;
   assign req_p[9]  = req_query_x;
   assign req_p[10] = req_query_y;
   assign req_p[11] = req_query_z;

   // coordinates ride along until the axis is known (stages 1 to 11)
   ptp_pkg::coord_set_type pts_ff [1:11];
   logic [11:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[10:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      pts_ff[1] <= req_p;
      for (int s = 2; s <= 11; s++) begin
         pts_ff[s] <= pts_ff[s-1];
      end
   end

   // ------------------------------------------------------------------------
   // stage 1: edge vectors, halved together when any one is too wide
   // ------------------------------------------------------------------------
   logic signed [32:0] diff_in [6];
   logic signed [32:0] half_in [6];
   logic               wide_in;
   logic signed [31:0] edge_ff [6];

   always_comb begin
      wide_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         diff_in[k]     = 33'(req_p[3+k]) - 33'(req_p[k]);
         diff_in[3+k]   = 33'(req_p[6+k]) - 33'(req_p[k]);
      end
      for (int k = 0; k < 6; k++) begin
         // round toward zero
         half_in[k] = (diff_in[k] + $signed({32'b0, diff_in[k][32]})) >>> 1;
         if (diff_in[k] > 33'sd2147483647 || diff_in[k] < -33'sd2147483647) begin
            wide_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 6; k++) begin
         edge_ff[k] <= wide_in ? half_in[k][31:0] : diff_in[k][31:0];
      end
   end

   // ------------------------------------------------------------------------
   // stage 2: cross product terms, stage 3: normal components
   // ------------------------------------------------------------------------
   logic signed [63:0] prod_ff [6];
   logic signed [63:0] norm_ff [3];

   always_ff @(posedge clock) begin
      prod_ff[0] <= edge_ff[1] * edge_ff[5];
      prod_ff[1] <= edge_ff[2] * edge_ff[4];
      prod_ff[2] <= edge_ff[2] * edge_ff[3];
      prod_ff[3] <= edge_ff[0] * edge_ff[5];
      prod_ff[4] <= edge_ff[0] * edge_ff[4];
      prod_ff[5] <= edge_ff[1] * edge_ff[3];
      norm_ff[0] <= prod_ff[0] - prod_ff[1];
      norm_ff[1] <= prod_ff[2] - prod_ff[3];
      norm_ff[2] <= prod_ff[4] - prod_ff[5];
   end

   // ------------------------------------------------------------------------
   // stage 4: magnitudes, stage 5: common shift, stage 6: scaled magnitudes
   // ------------------------------------------------------------------------
   logic [62:0] mag_ff [3];
   logic [62:0] mag5_ff [3];
   logic [62:0] mag_or_in;
   logic [5:0]  shift_in;
   logic [5:0]  shift_ff;
   logic [30:0] scaled_ff [3];

   always_comb begin
      mag_or_in = mag_ff[0] | mag_ff[1] | mag_ff[2];
      shift_in  = '0;
      // highest set bit above bit 30 sets the shift
      for (int b = 31; b < 63; b++) begin
         if (mag_or_in[b]) begin
            shift_in = 6'(b - 30);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         mag_ff[k]    <= norm_ff[k][63] ? 63'(-norm_ff[k]) : norm_ff[k][62:0];
         mag5_ff[k]   <= mag_ff[k];
         scaled_ff[k] <= 31'(mag5_ff[k] >> shift_ff);
      end
      shift_ff <= shift_in;
   end

   // ------------------------------------------------------------------------
   // stages 7 to 10: squares, squared norm, tol^2 times squared norm in two halves
   // ------------------------------------------------------------------------
   logic [61:0]     sq_ff [3];
   logic [31:0]     tol2_ff;
   logic [61:0]     sq8_ff [2];
   logic [63:0]     sum_ff;
   logic [31:0]     tol2_8_ff;
   logic [61:0]     sq9_ff [2];
   logic [63:0]     pp_lo_ff;
   logic [63:0]     pp_hi_ff;
   logic [61:0]     sq10_ff [2];
   logic [CmpW-1:0] rhs_ff;

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= scaled_ff[k] * scaled_ff[k];
      end
      tol2_ff   <= tol_ff * tol_ff;
      sum_ff    <= 64'(sq_ff[0]) + 64'(sq_ff[1]) + 64'(sq_ff[2]);
      tol2_8_ff <= tol2_ff;
      pp_lo_ff  <= tol2_8_ff * sum_ff[31:0];
      pp_hi_ff  <= tol2_8_ff * sum_ff[63:32];
      rhs_ff    <= CmpW'({pp_hi_ff, 32'b0}) + CmpW'(pp_lo_ff);
      for (int k = 0; k < 2; k++) begin
         sq8_ff[k]  <= sq_ff[k];
         sq9_ff[k]  <= sq8_ff[k];
         sq10_ff[k] <= sq9_ff[k];
      end
   end

   // ------------------------------------------------------------------------
   // stage 11: first axis whose share of the normal beats the tolerance
   // ------------------------------------------------------------------------
   logic [CmpW-1:0]   lhs_x_in;
   logic [CmpW-1:0]   lhs_y_in;
   ptp_pkg::axis_type axis_in;
   ptp_pkg::axis_type axis_ff;

   always_comb begin
      lhs_x_in = CmpW'(sq10_ff[0]) << (2 * COORD_FRAC_BITS);
      lhs_y_in = CmpW'(sq10_ff[1]) << (2 * COORD_FRAC_BITS);
      if (lhs_x_in > rhs_ff) begin
         axis_in = ptp_pkg::AXIS_X;
      end else if (lhs_y_in > rhs_ff) begin
         axis_in = ptp_pkg::AXIS_Y;
      end else begin
         axis_in = ptp_pkg::AXIS_Z;   // also a degenerate triangle
      end
   end

   always_ff @(posedge clock) begin
      axis_ff <= axis_in;
   end

   // ------------------------------------------------------------------------
   // stage 12: project, per edge span test and operand magnitudes
   // ------------------------------------------------------------------------
   logic signed [31:0] u_in [4];
   logic signed [31:0] v_in [4];
   logic signed [32:0] du_in [3];
   logic signed [32:0] dv_in [3];
   logic signed [32:0] t_in  [3];
   logic [31:0]        dmag_in [3];
   logic               span_in [3];

   logic               e_ok_ff  [3];
   logic               e_neg_ff [3];
   logic signed [31:0] e_av_ff  [3];
   logic [31:0]        e_d_ff   [3];
   logic [31:0]        e_dv_ff  [3];
   logic [31:0]        e_t_ff   [3];
   logic signed [31:0] qv12_ff;
   ptp_pkg::axis_type  axis12_ff;
   logic               vld12_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         u_in[i] = (axis_ff == ptp_pkg::AXIS_X) ? pts_ff[11][3*i+1] : pts_ff[11][3*i];
         v_in[i] = (axis_ff == ptp_pkg::AXIS_Z) ? pts_ff[11][3*i+1] : pts_ff[11][3*i+2];
      end
      for (int j = 0; j < 3; j++) begin
         du_in[j]   = 33'(u_in[(j+1)%3]) - 33'(u_in[j]);
         dv_in[j]   = 33'(v_in[(j+1)%3]) - 33'(v_in[j]);
         t_in[j]    = 33'(u_in[3]) - 33'(u_in[j]);
         dmag_in[j] = du_in[j][32] ? 32'(-du_in[j]) : du_in[j][31:0];
         span_in[j] = (u_in[3] >= u_in[j] && u_in[3] <= u_in[(j+1)%3]) ||
                      (u_in[3] <= u_in[j] && u_in[3] >= u_in[(j+1)%3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld12_ff <= 1'b0;
      end else begin
         vld12_ff <= vld_ff[11];
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         e_ok_ff[j]  <= span_in[j] && (dmag_in[j] > {16'b0, tol_ff});
         e_neg_ff[j] <= dv_in[j][32];
         e_av_ff[j]  <= v_in[j];
         e_d_ff[j]   <= dmag_in[j];
         e_dv_ff[j]  <= dv_in[j][32] ? 32'(-dv_in[j]) : dv_in[j][31:0];
         e_t_ff[j]   <= t_in[j][32] ? 32'(-t_in[j]) : t_in[j][31:0];
      end
      qv12_ff   <= v_in[3];
      axis12_ff <= axis_ff;
   end

   // ------------------------------------------------------------------------
   // stage 13 and divider: |dv|*|t| / |du|, one restoring step per stage
   // the quotient stays below 2^32 since |t| <= |du| on a spanning edge
   // ------------------------------------------------------------------------
   logic [31:0]        div_rem_ff [0:DS][3];
   logic [31:0]        div_sh_ff  [0:DS][3];   // dividend bits out, quotient in
   logic [31:0]        div_d_ff   [0:DS][3];
   logic               div_ok_ff  [0:DS][3];
   logic               div_neg_ff [0:DS][3];
   logic signed [31:0] div_av_ff  [0:DS][3];
   logic signed [31:0] div_qv_ff  [0:DS];
   ptp_pkg::axis_type  div_axis_ff [0:DS];
   logic [DS:0]        div_vld_ff;
   logic [63:0]        prod_in [3];
   logic [32:0]        trial_in [DS][3];
   logic               fit_in   [DS][3];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         prod_in[j] = e_dv_ff[j] * e_t_ff[j];
      end
      for (int s = 0; s < DS; s++) begin
         for (int j = 0; j < 3; j++) begin
            trial_in[s][j] = {div_rem_ff[s][j], div_sh_ff[s][j][31]};
            fit_in[s][j]   = trial_in[s][j] >= {1'b0, div_d_ff[s][j]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_vld_ff <= '0;
      end else begin
         div_vld_ff <= {div_vld_ff[DS-1:0], vld12_ff};
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < 3; j++) begin
         div_rem_ff[0][j] <= prod_in[j][63:32];
         div_sh_ff[0][j]  <= prod_in[j][31:0];
         div_d_ff[0][j]   <= e_d_ff[j];
         div_ok_ff[0][j]  <= e_ok_ff[j];
         div_neg_ff[0][j] <= e_neg_ff[j];
         div_av_ff[0][j]  <= e_av_ff[j];
      end
      div_qv_ff[0]   <= qv12_ff;
      div_axis_ff[0] <= axis12_ff;
      for (int s = 0; s < DS; s++) begin
         for (int j = 0; j < 3; j++) begin
            div_rem_ff[s+1][j] <= fit_in[s][j] ?
                                  32'(trial_in[s][j] - {1'b0, div_d_ff[s][j]}) :
                                  trial_in[s][j][31:0];
            div_sh_ff[s+1][j]  <= {div_sh_ff[s][j][30:0], fit_in[s][j]};
            div_d_ff[s+1][j]   <= div_d_ff[s][j];
            div_ok_ff[s+1][j]  <= div_ok_ff[s][j];
            div_neg_ff[s+1][j] <= div_neg_ff[s][j];
            div_av_ff[s+1][j]  <= div_av_ff[s][j];
         end
         div_qv_ff[s+1]   <= div_qv_ff[s];
         div_axis_ff[s+1] <= div_axis_ff[s];
      end
   end

   // ------------------------------------------------------------------------
   // output: classify edges against the query, register the result strobe
   // ------------------------------------------------------------------------
   logic signed [33:0] line_in [3];
   logic signed [33:0] q_in    [3];
   logic signed [33:0] hi_in;
   logic signed [33:0] lo_in;
   logic               up_in;
   logic               down_in;
   logic               on_in;
   logic               is_up_in   [3];
   logic               is_down_in [3];

   always_comb begin
      hi_in   = 34'(div_qv_ff[DS]) + $signed({18'b0, tol_ff});
      lo_in   = 34'(div_qv_ff[DS]) - $signed({18'b0, tol_ff});
      up_in   = 1'b0;
      down_in = 1'b0;
      on_in   = 1'b0;
      for (int j = 0; j < 3; j++) begin
         q_in[j]       = $signed({2'b0, div_sh_ff[DS][j]});
         line_in[j]    = 34'(div_av_ff[DS][j]) + (div_neg_ff[DS][j] ? -q_in[j] : q_in[j]);
         is_up_in[j]   = line_in[j] > hi_in;
         is_down_in[j] = line_in[j] < lo_in;
         if (div_ok_ff[DS][j]) begin
            up_in   = up_in   || is_up_in[j];
            down_in = down_in || (!is_up_in[j] && is_down_in[j]);
            on_in   = on_in   || (!is_up_in[j] && !is_down_in[j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= div_vld_ff[DS];
      end
   end

   always_ff @(posedge clock) begin
      rsp_contains  <= (up_in && down_in) || on_in;
      rsp_drop_axis <= div_axis_ff[DS];
   end

endmodule

// File: rtl/core/ptp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_checker
// port-level timing checks of the point-in-triangle pipeline
// ----------------------------------------------------------------------------
module ptp_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_drop_axis
);

   // every accepted command yields a strobe after the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(ptp_pkg::LATENCY) rsp_valid)
      else $error("accepted transfer produced no result");

   // no strobe without a command accepted one latency earlier
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, ptp_pkg::LATENCY))
      else $error("result without matching transfer");

   // reset flushes the pipeline
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("strobe right after reset");

   // reported axis is one of the three
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drop_axis == ptp_pkg::AXIS_X || rsp_drop_axis == ptp_pkg::AXIS_Y ||
                     rsp_drop_axis == ptp_pkg::AXIS_Z))
      else $error("invalid drop axis");

endmodule

bind point_in_triangle_projected ptp_checker u_ptp_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_drop_axis (rsp_drop_axis)
);
